>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the route lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int SlotW       = 7;
  localparam int AddrW       = 32;
  localparam int PortW       = 8;
  localparam int CountW      = 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } lpr_op_e;

  // Input beat
  typedef struct packed {
    lpr_op_e            op;
    logic [SlotW-1:0]   slot;
    logic [AddrW-1:0]   route_prefix;
    logic [AddrW-1:0]   route_mask;
    logic [PortW-1:0]   route_port;
    logic [AddrW-1:0]   dest_addr;
  } lpr_in_t;

  // Result beat
  typedef struct packed {
    logic               found;
    logic [PortW-1:0]   best_port;
    logic [SlotW-1:0]   best_slot;
  } lpr_out_t;

  // Table write broadcast to all cells
  typedef struct packed {
    logic               we;
    logic [SlotW-1:0]   slot;
    logic [AddrW-1:0]   prefix;
    logic [AddrW-1:0]   mask;
    logic [PortW-1:0]   port;
  } lpr_load_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic               hit;
    logic [AddrW-1:0]   mask;
    logic [PortW-1:0]   port;
    logic [SlotW-1:0]   slot;
    logic [AddrW-1:0]   dest;
  } lpr_rec_t;

endpackage

`default_nettype wire

>>> hdl/lpr_stream_if.sv
// ----------------------------------------------------------------------------
// lpr_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// One route entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cell #(
  parameter int Idx = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lpr_pkg::lpr_load_t        ld_i,
  input  wire logic [lpr_pkg::CountW-1:0] route_count_i,
  input  wire logic                      rec_valid_i,
  input  wire lpr_pkg::lpr_rec_t         rec_i,
  output logic                           rec_valid_o,
  output lpr_pkg::lpr_rec_t              rec_o
);
  import lpr_pkg::*;

  logic [AddrW-1:0] prefix_q;
  logic [AddrW-1:0] mask_q;
  logic [PortW-1:0] port_q;
  logic             wr_en;
  logic             active;
  logic             take;
  logic             valid_q;
  lpr_rec_t         rec_d;
  lpr_rec_t         rec_q;

  // Slots above the slot field range are never loaded
  assign wr_en  = ld_i.we && (Idx < (1 << SlotW)) && (ld_i.slot == SlotW'(Idx));
  assign active = Idx < int'(route_count_i);
  assign take   = active && ((rec_i.dest & mask_q) == prefix_q) &&
                  (!rec_i.hit || (mask_q > rec_i.mask));

  always_comb begin
    rec_d = rec_i;
    if (take) begin
      rec_d.hit  = 1'b1;
      rec_d.mask = mask_q;
      rec_d.port = port_q;
      rec_d.slot = SlotW'(Idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prefix_q <= ld_i.prefix;
      mask_q   <= ld_i.mask;
      port_q   <= ld_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

>>> hdl/longest_prefix_route_lookup_top.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_top
// IPv4 route table with longest-prefix lookup over a chain of entry cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                    Beat
//  req_i    in   op, slot, prefix, mask, port, dest_addr    load or lookup
//  rsp_o    out  found, best_port, best_slot                one per lookup
//  cfg_i    in   route_count (8 bit)                        register write
//
//  A load beat writes one cell when it is accepted.
//  A lookup's search record walks one cell per cycle down the chain of
//  TableDepth cells and then moves into the output register.
//  One item is in flight at a time; req_i.ready is low while a lookup runs,
//  so the next beat is accepted only once its result is in the output register.
//  A result stalled on rsp_o is parked and keeps req_i.ready low until it
//  moves into the output register.
//  Reset clears control state only; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module longest_prefix_route_lookup_top #(
  parameter int TableDepth = lpr_pkg::TABLE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lpr_stream_if.sink         req_i,
  lpr_stream_if.source       rsp_o,
  lpr_stream_if.sink         cfg_i
);
  import lpr_pkg::*;

  logic [CountW-1:0]   route_count_q;
  logic                busy_q;
  logic                out_v_q;
  lpr_out_t            out_q;
  logic                pend_v_q;
  lpr_out_t            pend_q;
  lpr_in_t             req;
  logic                req_acc;
  logic                lookup_acc;
  lpr_load_t           ld;
  logic [TableDepth:0] chain_v;
  lpr_rec_t            chain_rec [TableDepth+1];
  lpr_out_t            end_res;
  logic                out_free;
  logic                out_load;

  assign req         = req_i.payload;
  assign req_i.ready = !busy_q;
  assign req_acc     = req_i.valid && !busy_q;
  assign lookup_acc  = req_acc && (req.op == OP_LOOKUP);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
    end else if (cfg_i.valid) begin
      route_count_q <= cfg_i.payload;
    end
  end

  assign ld.we     = req_acc && (req.op == OP_LOAD);
  assign ld.slot   = req.slot;
  assign ld.prefix = req.route_prefix;
  assign ld.mask   = req.route_mask;
  assign ld.port   = req.route_port;

  // Launch an empty search record into the head of the chain
  assign chain_v[0]        = lookup_acc;
  assign chain_rec[0].hit  = 1'b0;
  assign chain_rec[0].mask = '0;
  assign chain_rec[0].port = '0;
  assign chain_rec[0].slot = '0;
  assign chain_rec[0].dest = req.dest_addr;

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    lpr_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ld_i          (ld),
      .route_count_i (route_count_q),
      .rec_valid_i   (chain_v[k]),
      .rec_i         (chain_rec[k]),
      .rec_valid_o   (chain_v[k+1]),
      .rec_o         (chain_rec[k+1])
    );
  end

  assign end_res.found     = chain_rec[TableDepth].hit;
  assign end_res.best_port = chain_rec[TableDepth].port;
  assign end_res.best_slot = chain_rec[TableDepth].slot;

  assign out_free = !out_v_q || rsp_o.ready;
  assign out_load = out_free && (chain_v[TableDepth] || pend_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (lookup_acc) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
      // Park the finished result while the output beat is stalled
      if (chain_v[TableDepth] && !out_free) begin
        pend_v_q <= 1'b1;
      end else if (out_free) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_v[TableDepth] && !out_free) begin
      pend_q <= end_res;
    end
    if (out_load) begin
      out_q <= chain_v[TableDepth] ? end_res : pend_q;
    end
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

  `ASSERT_ALWAYS(a_one_in_flight, $countones({chain_v[TableDepth:1], pend_v_q}) <= 1)
  `ASSERT_IMPL(a_pend_behind_out, pend_v_q, out_v_q)
  `ASSERT_NEXT(a_lookup_sets_busy, lookup_acc, busy_q)
  `ASSERT_IMPL(a_chain_only_busy, chain_v[TableDepth:1] != '0, busy_q)
  `ASSERT_IMPL(a_miss_zero, out_v_q && !out_q.found,
               (out_q.best_port == '0) && (out_q.best_slot == '0))

endmodule

`default_nettype wire
